/* src/bdr_pkg.sv */
`timescale 1ns / 1ps

package bdr_pkg;

    localparam int NUM_BTN = 5;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDLE_W  = 24;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = ADDR_W - 2;
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    localparam logic [CFG_W-1:0]   DEBOUNCE_RST = CFG_W'(20);
    localparam logic [CFG_W-1:0]   DELAY_RST    = CFG_W'(500);
    localparam logic [CFG_W-1:0]   PERIOD_RST   = CFG_W'(100);
    localparam logic [IDLE_W-1:0]  TIMEOUT_RST  = IDLE_W'(30000);
    localparam logic [NUM_BTN-1:0] ENABLE_RST   = NUM_BTN'(3);

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_DELAY    = 3'd1,
        REG_PERIOD   = 3'd2,
        REG_TIMEOUT  = 3'd3,
        REG_ENABLE   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]   debounce;
        logic [CFG_W-1:0]   delay;
        logic [CFG_W-1:0]   period;
        logic [IDLE_W-1:0]  timeout;
        logic [NUM_BTN-1:0] enable;
    } cfg_t;

    typedef struct packed {
        logic fire;
        logic rep;
        logic pressed;
    } lane_out_t;

    typedef struct packed {
        logic [NUM_BTN-1:0] press;
        logic [NUM_BTN-1:0] rep;
        logic               light;
        logic               any;
    } res_t;

endpackage

/* src/button_debounce_repeat_backlight_core.sv */
`timescale 1ns / 1ps
// Each result is computed combinationally from its tick and registered in the output buffer.
// Throughput: one tick per cycle while in_stall is low; all button lanes update in parallel.
// A two-entry output buffer lets the input keep flowing for one stalled result.
// Reset: marks, counters and idle count clear, backlight on, registers at
// their defaults (20, 500, 100, 30000, 3).

module button_debounce_repeat_backlight_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdr_pkg::ADDR_W-1:0]   paddr,
    input  logic [bdr_pkg::DATA_W-1:0]   pwdata,
    output logic [bdr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bdr_pkg::NUM_BTN-1:0]  level_pressed,
    input  logic [bdr_pkg::NUM_BTN-1:0]  fall_edges,
    input  logic                         player_running,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bdr_pkg::NUM_BTN-1:0]  press_mask,
    output logic [bdr_pkg::NUM_BTN-1:0]  repeat_mask,
    output logic                         backlight_on,
    output logic                         any_held
);

    bdr_pkg::cfg_t      cfg_reg;
    bdr_pkg::reg_idx_t  idx;
    logic               wr;

    bdr_pkg::lane_out_t [bdr_pkg::NUM_BTN-1:0] lane_out;
    bdr_pkg::res_t      res;
    bdr_pkg::res_t      out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               accept, take;

    assign pready = 1'b1;
    assign idx    = bdr_pkg::reg_idx_t'(paddr[bdr_pkg::ADDR_W-1:2]);
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce <= bdr_pkg::DEBOUNCE_RST;
            cfg_reg.delay    <= bdr_pkg::DELAY_RST;
            cfg_reg.period   <= bdr_pkg::PERIOD_RST;
            cfg_reg.timeout  <= bdr_pkg::TIMEOUT_RST;
            cfg_reg.enable   <= bdr_pkg::ENABLE_RST;
        end
        else if (wr)
        begin
            case (idx)
                bdr_pkg::REG_DEBOUNCE: cfg_reg.debounce <= pwdata[bdr_pkg::CFG_W-1:0];
                bdr_pkg::REG_DELAY:    cfg_reg.delay    <= pwdata[bdr_pkg::CFG_W-1:0];
                bdr_pkg::REG_PERIOD:   cfg_reg.period   <= pwdata[bdr_pkg::CFG_W-1:0];
                bdr_pkg::REG_TIMEOUT:  cfg_reg.timeout  <= pwdata[bdr_pkg::IDLE_W-1:0];
                bdr_pkg::REG_ENABLE:   cfg_reg.enable   <= pwdata[bdr_pkg::NUM_BTN-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bdr_pkg::REG_DEBOUNCE: prdata = bdr_pkg::DATA_W'(cfg_reg.debounce);
            bdr_pkg::REG_DELAY:    prdata = bdr_pkg::DATA_W'(cfg_reg.delay);
            bdr_pkg::REG_PERIOD:   prdata = bdr_pkg::DATA_W'(cfg_reg.period);
            bdr_pkg::REG_TIMEOUT:  prdata = bdr_pkg::DATA_W'(cfg_reg.timeout);
            bdr_pkg::REG_ENABLE:   prdata = bdr_pkg::DATA_W'(cfg_reg.enable);
            default:               prdata = '0;
        endcase
    end

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid & ~skid_valid_reg;
    assign take     = out_valid_reg & ~out_stall;

    for (genvar g = 0; g < bdr_pkg::NUM_BTN; g++)
    begin : g_lane
        bdr_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (accept),
            .level    (level_pressed[g]),
            .edge_hit (fall_edges[g]),
            .rep_en   (cfg_reg.enable[g]),
            .cfg      (cfg_reg),
            .lane_out (lane_out[g])
        );
    end

    bdr_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (accept),
        .running  (player_running),
        .timeout  (cfg_reg.timeout),
        .lane_out (lane_out),
        .res      (res)
    );

    // output buffer: main register plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign press_mask   = out_reg.press;
    assign repeat_mask  = out_reg.rep;
    assign backlight_on = out_reg.light;
    assign any_held     = out_reg.any;

endmodule

/* src/bdr_lane.sv */
`timescale 1ns / 1ps

module bdr_lane (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   level,
    input  logic                   edge_hit,
    input  logic                   rep_en,
    input  bdr_pkg::cfg_t          cfg,
    output bdr_pkg::lane_out_t     lane_out
);

    logic                       pressed_reg, pressed_next;
    logic                       handled_reg, handled_next;
    logic [bdr_pkg::CNT_W-1:0]  held_reg, held_next;
    logic [bdr_pkg::CNT_W-1:0]  rcnt_reg, rcnt_next;

    logic                       pressed1;
    logic [bdr_pkg::CNT_W-1:0]  rcnt1;
    logic [bdr_pkg::CNT_W-1:0]  dur;
    logic [bdr_pkg::CFG_W-1:0]  period_eff;
    logic [bdr_pkg::CMP_W-1:0]  reload_w;
    logic [bdr_pkg::CNT_W-1:0]  reload;
    logic                       fire;
    logic                       rep;
    logic                       rep_zone;

    always_comb
    begin
        pressed1 = edge_hit | pressed_reg;
        if (edge_hit)
        begin
            held_next = '0;
        end
        else if (pressed_reg && held_reg != bdr_pkg::CNT_MAX)
        begin
            held_next = held_reg + bdr_pkg::CNT_W'(1);
        end
        else
        begin
            held_next = held_reg;
        end
        rcnt1 = edge_hit ? '0 : rcnt_reg;

        pressed_next = pressed1 & level;
        dur          = pressed_next ? held_next : '0;
        fire         = (bdr_pkg::CMP_W'(dur) > bdr_pkg::CMP_W'(cfg.debounce))
                       && !(pressed_next && handled_reg);
        handled_next = (pressed_next & handled_reg) | fire;

        period_eff = (cfg.period == '0) ? bdr_pkg::CFG_W'(1) : cfg.period;
        reload_w   = bdr_pkg::CMP_W'(period_eff - bdr_pkg::CFG_W'(1));
        reload     = (reload_w > bdr_pkg::CMP_W'(bdr_pkg::CNT_MAX)) ? bdr_pkg::CNT_MAX
                                                                 : reload_w[bdr_pkg::CNT_W-1:0];

        rep_zone = (bdr_pkg::CMP_W'(dur) > bdr_pkg::CMP_W'(cfg.delay)) && rep_en;
        rep      = 1'b0;
        if (rep_zone)
        begin
            if (rcnt1 == '0)
            begin
                rcnt_next = reload;
                rep       = 1'b1;
            end
            else
            begin
                rcnt_next = rcnt1 - bdr_pkg::CNT_W'(1);
            end
        end
        else
        begin
            rcnt_next = '0;
        end
    end

    assign lane_out = '{fire: fire, rep: rep, pressed: pressed_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            handled_reg <= 1'b0;
            held_reg    <= '0;
            rcnt_reg    <= '0;
        end
        else if (step)
        begin
            pressed_reg <= pressed_next;
            handled_reg <= handled_next;
            held_reg    <= held_next;
            rcnt_reg    <= rcnt_next;
        end
    end

endmodule

/* src/bdr_merge.sv */
`timescale 1ns / 1ps

module bdr_merge (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      step,
    input  logic                                      running,
    input  logic [bdr_pkg::IDLE_W-1:0]                timeout,
    input  bdr_pkg::lane_out_t [bdr_pkg::NUM_BTN-1:0] lane_out,
    output bdr_pkg::res_t                             res
);

    logic [bdr_pkg::IDLE_W-1:0] idle_reg, idle_next;
    logic                       light_reg, light_next;
    logic [bdr_pkg::NUM_BTN-1:0] fire_v, rep_v, held_v;
    logic                       interaction;

    always_comb
    begin
        for (int i = 0; i < bdr_pkg::NUM_BTN; i++)
        begin
            fire_v[i] = lane_out[i].fire;
            rep_v[i]  = lane_out[i].rep;
            held_v[i] = lane_out[i].pressed;
        end
        interaction = (|fire_v) | (|rep_v);
        if (interaction)
        begin
            idle_next  = '0;
            light_next = 1'b1;
        end
        else
        begin
            idle_next  = (idle_reg == bdr_pkg::IDLE_MAX) ? idle_reg
                                                        : idle_reg + bdr_pkg::IDLE_W'(1);
            light_next = light_reg;
        end
        if (idle_next > timeout && running)
        begin
            light_next = 1'b0;
        end
    end

    assign res = '{press: fire_v & {bdr_pkg::NUM_BTN{light_reg}},
                   rep:   rep_v,
                   light: light_next,
                   any:   |held_v};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg  <= '0;
            light_reg <= 1'b1;
        end
        else if (step)
        begin
            idle_reg  <= idle_next;
            light_reg <= light_next;
        end
    end

endmodule

/* src/bdr_checker.sv */
`timescale 1ns / 1ps

module bdr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [bdr_pkg::NUM_BTN-1:0] press_mask,
    input logic [bdr_pkg::NUM_BTN-1:0] repeat_mask,
    input logic                        backlight_on,
    input logic                        any_held
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(press_mask)
            && $stable(repeat_mask) && $stable(backlight_on) && $stable(any_held))
        else $error("stalled result changed");

    // every transfer in leaves a valid result at the output in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("transfer gave no result");

    // empty buffer never back-pressures
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("stall while buffer empty");

    // any event lights the backlight
    a_event_light: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (press_mask != '0 || repeat_mask != '0) |-> backlight_on)
        else $error("event with backlight off");

    // events only come from held buttons
    a_event_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (press_mask != '0 || repeat_mask != '0) |-> any_held)
        else $error("event without held button");

endmodule

bind button_debounce_repeat_backlight_core bdr_checker u_bdr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .press_mask   (press_mask),
    .repeat_mask  (repeat_mask),
    .backlight_on (backlight_on),
    .any_held     (any_held)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import bdr_pkg::*;

    typedef struct {
        logic [NUM_BTN-1:0] lvl;
        logic [NUM_BTN-1:0] edg;
        logic               run;
        int unsigned        reps;
        bit                 fixed;
        res_t               want;
    } step_t;

    localparam res_t RES_IDLE      = '{press: '0, rep: '0, light: 1'b1, any: 1'b0};
    localparam res_t RES_HELD      = '{press: '0, rep: '0, light: 1'b1, any: 1'b1};
    localparam res_t RES_DARK_HELD = '{press: '0, rep: '0, light: 1'b0, any: 1'b1};

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [NUM_BTN-1:0]  level_pressed  = '0;
    logic [NUM_BTN-1:0]  fall_edges     = '0;
    logic                player_running = 1'b0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [NUM_BTN-1:0]  press_mask;
    logic [NUM_BTN-1:0]  repeat_mask;
    logic                backlight_on;
    logic                any_held;

    // predictor copy of the block
    cfg_t cfg = '{debounce: DEBOUNCE_RST, delay: DELAY_RST, period: PERIOD_RST,
                  timeout: TIMEOUT_RST, enable: ENABLE_RST};
    logic [NUM_BTN-1:0] mark_pressed = '0;
    logic [NUM_BTN-1:0] mark_handled = '0;
    logic [CNT_W-1:0]   hold_cnt [NUM_BTN] = '{default: '0};
    logic [CNT_W-1:0]   rpt_cnt  [NUM_BTN] = '{default: '0};
    logic [IDLE_W-1:0]  idle_cnt = '0;
    logic               light    = 1'b1;

    res_t  due_results[$];
    step_t steps[$];
    int    errors     = 0;
    int    mismatches = 0;
    int    n_results  = 0;
    int    n_ticks    = 0;
    int    n_press    = 0;
    int    n_rpt      = 0;
    int    n_dark     = 0;
    int    n_cfg      = 0;
    int    gap_pct    = 20;
    bit    quiet      = 1'b0;
    bit    hold_req   = 1'b0;

    always #1 clk = ~clk;

    button_debounce_repeat_backlight_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .level_pressed  (level_pressed),
        .fall_edges     (fall_edges),
        .player_running (player_running),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .press_mask     (press_mask),
        .repeat_mask    (repeat_mask),
        .backlight_on   (backlight_on),
        .any_held       (any_held)
    );

    function automatic res_t debounce_tick(logic [NUM_BTN-1:0] lvl, logic [NUM_BTN-1:0] edg,
                                           logic run);
        res_t             r;
        logic             lit_before;
        logic             hit;
        logic [CFG_W-1:0] per;
        logic [CNT_W-1:0] dur;
        r          = '0;
        lit_before = light;
        hit        = 1'b0;
        per        = (cfg.period == '0) ? CFG_W'(1) : cfg.period;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            if (edg[b])
            begin
                mark_pressed[b] = 1'b1;
                hold_cnt[b]     = '0;
                rpt_cnt[b]      = '0;
            end
            else if (mark_pressed[b] && hold_cnt[b] != CNT_MAX)
                hold_cnt[b] = hold_cnt[b] + 1'b1;
            if (!lvl[b])
                mark_pressed[b] = 1'b0;
            if (!mark_pressed[b])
                mark_handled[b] = 1'b0;
            dur = mark_pressed[b] ? hold_cnt[b] : '0;
            if (dur > cfg.debounce && !mark_handled[b])
            begin
                mark_handled[b] = 1'b1;
                hit             = 1'b1;
                if (lit_before)
                    r.press[b] = 1'b1;
            end
            if (dur > cfg.delay && cfg.enable[b])
            begin
                if (rpt_cnt[b] == '0)
                begin
                    rpt_cnt[b] = CNT_W'(per - 1'b1);
                    r.rep[b]   = 1'b1;
                    hit        = 1'b1;
                end
                else
                    rpt_cnt[b] = rpt_cnt[b] - 1'b1;
            end
            else
                rpt_cnt[b] = '0;
        end
        if (hit)
        begin
            idle_cnt = '0;
            light    = 1'b1;
        end
        else if (idle_cnt != IDLE_MAX)
            idle_cnt = idle_cnt + 1'b1;
        if (idle_cnt > cfg.timeout && run)
            light = 1'b0;
        r.light = light;
        r.any   = |mark_pressed;
        return r;
    endfunction

    function automatic step_t mk_step(logic [NUM_BTN-1:0] lvl, logic [NUM_BTN-1:0] edg,
                                      logic run, int unsigned reps, bit fixed, res_t want);
        step_t s;
        s.lvl   = lvl;
        s.edg   = edg;
        s.run   = run;
        s.reps  = reps;
        s.fixed = fixed;
        s.want  = want;
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] reg_field(cfg_t c, reg_idx_t idx);
        case (idx)
            REG_DEBOUNCE: return DATA_W'(c.debounce);
            REG_DELAY:    return DATA_W'(c.delay);
            REG_PERIOD:   return DATA_W'(c.period);
            REG_TIMEOUT:  return DATA_W'(c.timeout);
            REG_ENABLE:   return DATA_W'(c.enable);
            default:      return '0;
        endcase
    endfunction

    task automatic cfg_access(input reg_idx_t idx, input logic wr,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_regs();
        reg_idx_t          idx;
        logic [DATA_W-1:0] rd;
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_access(idx, 1'b0, '0, rd);
            if (rd !== reg_field(cfg, idx))
            begin
                errors++;
                $display("register %s reads %h, expected %h", idx.name(), rd,
                         reg_field(cfg, idx));
            end
            idx = idx.next();
        end
    endtask

    task automatic write_cfg(input cfg_t c);
        reg_idx_t          idx;
        logic [DATA_W-1:0] rd;
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_access(idx, 1'b1, reg_field(c, idx), rd);
            idx = idx.next();
        end
        cfg = c;
        n_cfg++;
        check_regs();
    endtask

    task automatic send_tick(input logic [NUM_BTN-1:0] lvl, input logic [NUM_BTN-1:0] edg,
                             input logic run, input bit fixed, input res_t fixed_res);
        res_t r;
        in_valid       <= 1'b1;
        level_pressed  <= lvl;
        fall_edges     <= edg;
        player_running <= run;
        do
            @(posedge clk);
        while (in_stall);
        r = debounce_tick(lvl, edg, run);
        due_results.push_back(fixed ? fixed_res : r);
        n_ticks++;
        if (n_ticks % 100 == 0)
            gap_pct = $urandom_range(0, 2) * 15;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly press/hold/release episodes, some raw noise ticks
    task automatic random_ticks(input int count, input int span);
        logic [NUM_BTN-1:0] cur;
        logic [NUM_BTN-1:0] set;
        logic [NUM_BTN-1:0] edg_r;
        logic               run;
        int                 stop;
        int                 hold;
        cur  = '0;
        stop = n_ticks + count;
        while (n_ticks < stop)
        begin
            run = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 15)
            begin
                cur = NUM_BTN'($urandom);
                send_tick(cur, NUM_BTN'($urandom), 1'($urandom), 1'b0, '0);
            end
            else
            begin
                set = NUM_BTN'($urandom_range(1, (1 << NUM_BTN) - 1));
                cur = cur | set;
                send_tick(cur, set, run, 1'b0, '0);
                hold = $urandom_range(0, span);
                repeat (hold)
                begin
                    edg_r = ($urandom_range(0, 15) == 0) ? (cur & NUM_BTN'($urandom)) : '0;
                    send_tick(cur, edg_r, run, 1'b0, '0);
                end
                cur = cur & NUM_BTN'($urandom);
            end
        end
    endtask

    // receiver side
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (int n = 0; n < 300; n++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {press_mask, repeat_mask, backlight_on, any_held};
            n_results++;
            n_press += $countones(got.press);
            n_rpt   += $countones(got.rep);
            if (!got.light)
                n_dark++;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("result %0d arrived with nothing pending", n_results);
            end
            else
            begin
                want = due_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: press %h/%h repeat %h/%h light %b/%b ",
                                  "held %b/%b (exp/got)"},
                                 n_results, want.press, got.press, want.rep, got.rep,
                                 want.light, got.light, want.any, got.any);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", due_results.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        cfg_t c;
        int   len;
        int   span;

        steps.push_back(mk_step(5'h00, 5'h00, 1'b0, 1, 1'b1, RES_IDLE));
        // edge without low level: marked and cleared at once
        steps.push_back(mk_step(5'h00, 5'h1F, 1'b0, 1, 1'b1, RES_IDLE));
        steps.push_back(mk_step(5'h1F, 5'h1F, 1'b0, 1, 1'b1, RES_HELD));
        steps.push_back(mk_step(5'h1F, 5'h00, 1'b0, 6, 1'b0, '0));
        steps.push_back(mk_step(5'h00, 5'h00, 1'b0, 1, 1'b1, RES_IDLE));
        steps.push_back(mk_step(5'h00, 5'h00, 1'b1, 6, 1'b0, '0));
        steps.push_back(mk_step(5'h03, 5'h03, 1'b1, 1, 1'b1, RES_DARK_HELD));
        // press swallowed while dark, repeat still delivered
        steps.push_back(mk_step(5'h03, 5'h00, 1'b1, 10, 1'b0, '0));
        steps.push_back(mk_step(5'h10, 5'h10, 1'b1, 1, 1'b0, '0));
        steps.push_back(mk_step(5'h10, 5'h00, 1'b1, 2, 1'b0, '0));
        steps.push_back(mk_step(5'h10, 5'h10, 1'b1, 1, 1'b0, '0));
        steps.push_back(mk_step(5'h10, 5'h00, 1'b1, 5, 1'b0, '0));
        steps.push_back(mk_step(5'h00, 5'h10, 1'b0, 1, 1'b0, '0));
        steps.push_back(mk_step(5'h08, 5'h08, 1'b0, 1, 1'b0, '0));
        steps.push_back(mk_step(5'h08, 5'h00, 1'b0, 4, 1'b0, '0));
        steps.push_back(mk_step(5'h01, 5'h01, 1'b1, 1, 1'b0, '0));
        // long hold; repeats must keep the backlight on
        steps.push_back(mk_step(5'h01, 5'h00, 1'b1, 40, 1'b0, '0));
        steps.push_back(mk_step(5'h00, 5'h00, 1'b0, 1, 1'b1, RES_IDLE));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_regs();

        write_cfg('{debounce: 16'd2, delay: 16'd2, period: 16'd3, timeout: 24'd3,
                    enable: 5'b10101});
        foreach (steps[i])
            repeat (steps[i].reps)
                send_tick(steps[i].lvl, steps[i].edg, steps[i].run, steps[i].fixed,
                          steps[i].want);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    c = '{16'd0, 16'd0, 16'd0, 24'd0, 5'h1F};            len = 250; span = 8;
                end
                1:
                begin
                    c = '{16'd1, 16'd3, 16'd1, 24'd2, 5'h0A};            len = 250; span = 12;
                end
                2:
                begin
                    c = '{16'd3, 16'd6, 16'd4, 24'd10, 5'h15};           len = 250; span = 30;
                end
                3:
                begin
                    c = '{16'hFFFF, 16'd2, 16'd2, 24'd5, 5'h1F};         len = 250; span = 15;
                end
                4:
                begin
                    c = '{16'd2, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 5'h1F}; len = 250; span = 12;
                end
                5:
                begin
                    c = '{16'd5, 16'd8, 16'hFFFF, 24'd1, 5'h1F};         len = 250; span = 25;
                end
                6:
                begin
                    c = '{16'd4, 16'd10, 16'd3, 24'd20, 5'h00};          len = 250; span = 30;
                end
                default:
                begin
                    c = '{16'd2, 16'd4, 16'd2, 24'd6, 5'h1F};            len = 200; span = 15;
                end
            endcase
            quiet = (p == 7);
            write_cfg(c);
            if (p == 2)
            begin
                hold_req = 1'b1;
                gap_pct  = 0;
            end
            random_ticks(len, span);
            drain();
        end
        repeat (8) @(posedge clk);

        $display("%0d ticks over %0d register settings; %0d presses, %0d repeats, %0d dark",
                 n_ticks, n_cfg, n_press, n_rpt, n_dark);
        $display("%0d results checked, %0d mismatches, %0d failures",
                 n_results, mismatches, errors);
        if (errors == 0 && due_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
src/bdr_pkg.sv
src/bdr_lane.sv
src/bdr_merge.sv
src/button_debounce_repeat_backlight_core.sv
src/bdr_checker.sv
tb/sv/tb.sv
